// ----- design/a2a_pkg.sv -----
// Shared types and constants for the atan2 approximation pipeline.
`timescale 1ns / 1ps

package a2a_pkg;

	localparam logic [15:0] PI_Q13      = 16'd25736;
	localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
	localparam logic [15:0] QPI_Q16     = 16'd51472;
	localparam logic [15:0] C1_Q16      = 16'd16037;
	localparam logic [12:0] C2_Q16      = 13'd4345;
	localparam int          A_WIDTH     = 16;
	localparam int          ANGLE_WIDTH = 16;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic xzero;
		logic yzero;
		logic swap;
		logic eq;
	} a2a_flags_t;

endpackage

// ----- design/atan2_approximation_unit.sv -----
// Top level of the four-quadrant atan2 approximation pipeline.
// Stages: 1 input, 16 divider, 4 polynomial, from input transfer to result.
// Throughput: one pair per cycle unless output stalls; bit-per-stage divider is 16 deep.
// Each stage advances when empty or when the next stage moves, so bubbles collapse on a stall.
// Reset (arst_n low) clears all stage valid bits at once; data registers are not reset.
`timescale 1ns / 1ps

module atan2_approximation_unit import a2a_pkg::*; #(
	parameter int INPUT_WIDTH = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// x_coord [INPUT_WIDTH-1:0], y_coord [2*INPUT_WIDTH-1:INPUT_WIDTH], zero fill
	input  logic [((2*INPUT_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// angle [15:0]
	output logic [ANGLE_WIDTH-1:0]                 m_axis_tdata
);

	localparam int W = INPUT_WIDTH;

	logic               f_valid, f_ready;
	logic [W-1:0]       f_mx, f_mn;
	a2a_flags_t         f_flags;

	logic               d_valid, d_ready;
	logic [A_WIDTH-1:0] d_quot;
	a2a_flags_t         d_flags;

	a2a_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.x_coord   (s_axis_tdata[W-1:0]),
		.y_coord   (s_axis_tdata[2*W-1:W]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.mx        (f_mx),
		.mn        (f_mn),
		.flags     (f_flags)
	);

	a2a_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.mx        (f_mx),
		.mn        (f_mn),
		.flags     (f_flags),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.quot      (d_quot),
		.out_flags (d_flags)
	);

	a2a_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.quot      (d_quot),
		.flags     (d_flags),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.angle     (m_axis_tdata)
	);

endmodule

// ----- design/a2a_front.sv -----
// Input stage: magnitudes, min/max ordering and case flags.
`timescale 1ns / 1ps

module a2a_front import a2a_pkg::*; #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] x_coord,
	input  logic [W-1:0] y_coord,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] mx,
	output logic [W-1:0] mn,
	output a2a_flags_t   flags
);

	localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

	logic         xneg, yneg;
	logic [W-1:0] xmag, ymag;
	logic         swap;
	a2a_flags_t   flags_d;

	logic         v_s1;
	logic [W-1:0] mx_s1, mn_s1;
	a2a_flags_t   flags_s1;

	assign xneg = x_coord[W-1];
	assign yneg = y_coord[W-1];
	assign xmag = xneg ? (~x_coord + ONE) : x_coord;
	assign ymag = yneg ? (~y_coord + ONE) : y_coord;
	assign swap = ymag > xmag;

	always_comb begin
		flags_d.xneg  = xneg;
		flags_d.yneg  = yneg;
		flags_d.xzero = (xmag == '0);
		flags_d.yzero = (ymag == '0);
		flags_d.swap  = swap;
		flags_d.eq    = (xmag == ymag);
	end

	assign in_ready = ~v_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mx_s1    <= swap ? ymag : xmag;
			mn_s1    <= swap ? xmag : ymag;
			flags_s1 <= flags_d;
		end
	end

	assign out_valid = v_s1;
	assign mx        = mx_s1;
	assign mn        = mn_s1;
	assign flags     = flags_s1;

endmodule

// ----- design/a2a_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for min/max ratio.
`timescale 1ns / 1ps

module a2a_div import a2a_pkg::*; #(
	parameter int W = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [W-1:0]       mx,
	input  logic [W-1:0]       mn,
	input  a2a_flags_t         flags,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [A_WIDTH-1:0] quot,
	output a2a_flags_t         out_flags
);

	localparam int N = A_WIDTH;

	logic               v_s    [N];
	logic               rdy    [N];
	logic [W-1:0]       rem_s  [N];
	logic [W-1:0]       mx_s   [N];
	logic [A_WIDTH-1:0] quot_s [N];
	a2a_flags_t         flags_s[N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			logic               prev_v;
			logic [W-1:0]       prev_rem;
			logic [W-1:0]       prev_mx;
			logic [A_WIDTH-1:0] prev_quot;
			a2a_flags_t         prev_flags;
			logic [W:0]         dbl;
			logic [W:0]         diff;
			logic               bit_q;

			if (k == 0) begin : g_first
				assign prev_v     = in_valid;
				assign prev_rem   = mn;
				assign prev_mx    = mx;
				assign prev_quot  = '0;
				assign prev_flags = flags;
			end else begin : g_next
				assign prev_v     = v_s[k-1];
				assign prev_rem   = rem_s[k-1];
				assign prev_mx    = mx_s[k-1];
				assign prev_quot  = quot_s[k-1];
				assign prev_flags = flags_s[k-1];
			end

			if (k == N-1) begin : g_last
				assign rdy[k] = ~v_s[k] | out_ready;
			end else begin : g_mid
				assign rdy[k] = ~v_s[k] | rdy[k+1];
			end

			assign dbl   = {prev_rem, 1'b0};
			assign diff  = dbl - {1'b0, prev_mx};
			assign bit_q = (dbl >= {1'b0, prev_mx});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					v_s[k] <= prev_v;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && prev_v) begin
					rem_s[k]   <= bit_q ? diff[W-1:0] : dbl[W-1:0];
					mx_s[k]    <= prev_mx;
					quot_s[k]  <= {prev_quot[A_WIDTH-2:0], bit_q};
					flags_s[k] <= prev_flags;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = v_s[N-1];
	assign quot      = quot_s[N-1];
	assign out_flags = flags_s[N-1];

endmodule

// ----- design/a2a_poly.sv -----
// Polynomial evaluation, rounding and quadrant folding stages.
`timescale 1ns / 1ps

module a2a_poly import a2a_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [A_WIDTH-1:0]     quot,
	input  a2a_flags_t             flags,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ANGLE_WIDTH-1:0] angle
);

	localparam logic [31:0] RND = 32'd32768;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [A_WIDTH-1:0] a;
	logic [16:0]        a_c;
	logic [28:0]        tp;
	logic [32:0]        up;
	logic [31:0]        pp;

	logic [28:0]        tp_s1;
	logic [32:0]        up_s1;
	logic [31:0]        pp_s1;
	a2a_flags_t         flags_s1;

	logic [28:0]        t_sum;
	logic [32:0]        u_sum;
	logic [31:0]        p_sum;
	logic [14:0]        t_s2, u_s2;
	logic [15:0]        pr_s2;
	a2a_flags_t         flags_s2;

	logic [29:0]        ut;
	logic [29:0]        ut_s3;
	logic [15:0]        pr_s3;
	a2a_flags_t         flags_s3;

	logic [29:0]        ut_sum;
	logic [16:0]        q;
	logic [15:0]        phi, f1, f2, f3, res;
	logic [15:0]        angle_s4;

	assign rdy_s4 = ~v_s4 | out_ready;
	assign rdy_s3 = ~v_s3 | rdy_s4;
	assign rdy_s2 = ~v_s2 | rdy_s3;
	assign rdy_s1 = ~v_s1 | rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign a   = flags.eq ? {A_WIDTH{1'b1}} : quot;
	assign a_c = 17'h10000 - {1'b0, a};
	assign tp  = 29'(C2_Q16) * 29'(a);
	assign up  = 33'(a) * 33'(a_c);
	assign pp  = 32'(QPI_Q16) * 32'(a);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			tp_s1    <= tp;
			up_s1    <= up;
			pp_s1    <= pp;
			flags_s1 <= flags;
		end
	end

	assign t_sum = tp_s1 + RND[28:0];
	assign u_sum = up_s1 + {1'b0, RND};
	assign p_sum = pp_s1 + RND;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			t_s2     <= C1_Q16[14:0] + {2'b00, t_sum[28:16]};
			u_s2     <= u_sum[30:16];
			pr_s2    <= p_sum[31:16];
			flags_s2 <= flags_s1;
		end
	end

	assign ut = 30'(u_s2) * 30'(t_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			ut_s3    <= ut;
			pr_s3    <= pr_s2;
			flags_s3 <= flags_s2;
		end
	end

	assign ut_sum = ut_s3 + RND[29:0];
	assign q      = {1'b0, pr_s3} + {3'b000, ut_sum[29:16]} + 17'd4;
	assign phi    = {2'b00, q[16:3]};
	assign f1     = flags_s3.swap ? (HALF_PI_Q13 - phi) : phi;
	assign f2     = flags_s3.xneg ? (PI_Q13 - f1) : f1;
	assign f3     = flags_s3.yneg ? (16'd0 - f2) : f2;

	always_comb begin
		if (flags_s3.xzero) begin
			if (flags_s3.yzero) begin
				res = '0;
			end else if (flags_s3.yneg) begin
				res = 16'd0 - HALF_PI_Q13;
			end else begin
				res = HALF_PI_Q13;
			end
		end else if (flags_s3.yzero) begin
			res = flags_s3.xneg ? PI_Q13 : 16'd0;
		end else begin
			res = f3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			angle_s4 <= res;
		end
	end

	assign out_valid = v_s4;
	assign angle     = angle_s4;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the atan2 approximation pipeline on its stream ports.
`timescale 1ns / 1ps

module tb;
	import a2a_pkg::*;

	localparam int IN_W           = 24;
	localparam int DATA_W         = ((2*IN_W+7)/8)*8;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [IN_W-1:0] MAX_POS = 24'h7FFFFF;
	localparam logic [IN_W-1:0] MAX_NEG = 24'h800000;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [15:0]       m_axis_tdata;

	logic [15:0] angle_q[$];
	bit          idle_on;
	int          stall_left   = 0;
	int          error_count  = 0;
	int          pair_count;
	int          angle_count  = 0;
	int          quiet_cycles = 0;

	atan2_approximation_unit #(.INPUT_WIDTH(IN_W)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [15:0] expected_angle(logic [IN_W-1:0] xw, logic [IN_W-1:0] yw);
		longint unsigned ax, ay, mx, mn, a, t, u, q;
		logic [15:0]     phi;
		ax = 64'(xw);
		ay = 64'(yw);
		if (xw[IN_W-1])
			ax = (64'd1 << IN_W) - ax;
		if (yw[IN_W-1])
			ay = (64'd1 << IN_W) - ay;
		if (ax == 0) begin
			if (ay == 0)
				phi = 16'd0;
			else
				phi = yw[IN_W-1] ? 16'd0 - HALF_PI_Q13 : HALF_PI_Q13;
		end else if (ay == 0) begin
			phi = xw[IN_W-1] ? PI_Q13 : 16'd0;
		end else begin
			mx = (ax > ay) ? ax : ay;
			mn = (ax > ay) ? ay : ax;
			a = (mn << 16) / mx;
			if (a > 65535)
				a = 65535;
			t = C1_Q16 + ((C2_Q16 * a + 32768) >> 16);
			u = (a * (65536 - a) + 32768) >> 16;
			q = ((QPI_Q16 * a + 32768) >> 16) + ((u * t + 32768) >> 16);
			phi = 16'((q + 4) >> 3);
			if (ay > ax)
				phi = HALF_PI_Q13 - phi;
			if (xw[IN_W-1])
				phi = PI_Q13 - phi;
			if (yw[IN_W-1])
				phi = 16'd0 - phi;
		end
		return phi;
	endfunction

	task automatic send_pair(logic [IN_W-1:0] xw, logic [IN_W-1:0] yw);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= DATA_W'({yw, xw});
		do
			@(posedge clk);
		while (!s_axis_tready);
		angle_q.push_back(expected_angle(xw, yw));
		pair_count++;
	endtask

	task automatic test_special_cases();
		send_pair(24'd0, 24'd0);
		send_pair(24'd0, 24'd5);
		send_pair(24'd0, -24'sd5);
		send_pair(24'd7, 24'd0);
		send_pair(-24'sd7, 24'd0);
		send_pair(MAX_NEG, 24'd0);
		send_pair(24'd0, MAX_NEG);
		send_pair(MAX_POS, MAX_POS);
		send_pair(MAX_NEG, MAX_NEG);
		send_pair(MAX_NEG, MAX_POS);
		send_pair(MAX_POS, MAX_NEG);
		send_pair(24'd100, 24'd100);
		send_pair(-24'sd100, 24'd100);
		send_pair(-24'sd100, -24'sd100);
		send_pair(24'd100, -24'sd100);
		send_pair(24'd1, 24'd1);
		send_pair(24'd1, MAX_POS);
		send_pair(MAX_POS, 24'd1);
		send_pair(-24'sd1, MAX_NEG);
		send_pair(MAX_NEG, -24'sd1);
		send_pair(24'd3, 24'd4);
		send_pair(-24'sd4, 24'd3);
	endtask

	task automatic send_random_pair();
		int          mag;
		int          ymag;
		logic [IN_W-1:0] xw, yw;
		case ($urandom_range(0, 5))
			0: begin
				xw = IN_W'($urandom);
				yw = IN_W'($urandom);
			end
			1: begin
				xw = IN_W'($urandom_range(0, 128) - 64);
				yw = IN_W'($urandom_range(0, 128) - 64);
			end
			2: begin
				mag  = $urandom_range(1, 8388600);
				ymag = mag + $urandom_range(0, 4) - 2;
				if (ymag < 1)
					ymag = 1;
				xw = IN_W'($urandom_range(0, 1) ? -mag : mag);
				yw = IN_W'($urandom_range(0, 1) ? -ymag : ymag);
			end
			3: begin
				xw = IN_W'($urandom);
				yw = 24'd0;
				if ($urandom_range(0, 1)) begin
					yw = xw;
					xw = 24'd0;
				end
			end
			4: begin
				case ($urandom_range(0, 4))
					0: xw = MAX_POS;
					1: xw = MAX_NEG;
					2: xw = -24'sd1;
					3: xw = 24'd1;
					default: xw = 24'd0;
				endcase
				case ($urandom_range(0, 4))
					0: yw = MAX_POS;
					1: yw = MAX_NEG;
					2: yw = -24'sd1;
					3: yw = 24'd1;
					default: yw = IN_W'($urandom);
				endcase
			end
			default: begin
				xw = IN_W'($urandom);
				yw = IN_W'($urandom_range(0, 2000) - 1000);
				if ($urandom_range(0, 1)) begin
					{xw, yw} = {yw, xw};
				end
			end
		endcase
		send_pair(xw, yw);
	endtask

	task automatic test_random_pairs(int count);
		idle_on = 1'b1;
		repeat (count) send_random_pair();
	endtask

	task automatic test_back_to_back(int count);
		idle_on = 1'b0;
		repeat (count) send_random_pair();
	endtask

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if (idle_on && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 12);
		m_axis_tready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			angle_count++;
			if (angle_q.size() == 0) begin
				$error("angle: expected none, got %0d", $signed(m_axis_tdata));
				error_count++;
			end else begin
				want = angle_q.pop_front();
				if (m_axis_tdata !== want) begin
					$error("angle: expected %0d, got %0d", $signed(want), $signed(m_axis_tdata));
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		idle_on       = 1'b1;
		pair_count    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_pairs(900);
		test_back_to_back(250);

		s_axis_tvalid <= 1'b0;
		while (angle_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d coordinate pairs (zero axes, extremes, diagonals, random)", pair_count);
		$display("Checked %0d angles with random gaps and stalls, then back-to-back",
			angle_count);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
